@@ rtl/core/seeded_key_material_mixer_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the seeded key material mixer
// Concurrent checks on clk with rst as the disable condition; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEEDED_KEY_MATERIAL_MIXER_TOP_DEFINES_SVH
`define SEEDED_KEY_MATERIAL_MIXER_TOP_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SKMM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skmm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SKMM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skmm: next-cycle check failed");

`else

`define SKMM_ASSERT_SAME(label, ante, cons)
`define SKMM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/skmm_pkg.sv @@
// ----------------------------------------------------------------------------
// skmm_pkg
// Shared types, constants and mixing functions of the key material mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package skmm_pkg;

  localparam int NUM_WORDS       = 8;
  localparam int WORD_W          = 32;
  localparam int WORD_IDX_W      = 3;
  localparam int RC_IDX_W        = 4;
  localparam int NUM_RC          = 16;
  localparam int ROUNDS_DEF      = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [WORD_W-1:0] FMIX_C1 = 32'h85EBCA6B;
  localparam logic [WORD_W-1:0] FMIX_C2 = 32'hC2B2AE35;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } quad_t;

  localparam logic [WORD_W-1:0] INIT_WORDS [NUM_WORDS] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [WORD_W-1:0] MIX_WORDS [NUM_WORDS] = '{
    32'h7E2B84F1, 32'h3A9C5D06, 32'hC8F13E72, 32'h54D0A9B3,
    32'h196BE8C4, 32'hAF742D50, 32'h63E9B187, 32'hDB05F6CA
  };

  localparam logic [WORD_W-1:0] ROUND_CONSTS [NUM_RC] = '{
    32'hB7E15163, 32'h8AED2A6A, 32'h5DB8C971, 32'h30846878,
    32'h0350077F, 32'hD61BA686, 32'hA8E7458D, 32'h7BB2E494,
    32'h4E7E839B, 32'h214A22A2, 32'hF415C1A9, 32'hC6E160B0,
    32'h99ACFFB7, 32'h6C789EBE, 32'h3F443DC5, 32'h120FDCCC
  };

  // Rotate right by a constant amount between 1 and 31.
  function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] x, input int n);
    return (x >> n) | (x << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] round_const(input logic [RC_IDX_W-1:0] idx);
    return ROUND_CONSTS[idx];
  endfunction

  // Starting state for one seed.
  function automatic state_t init_state(input logic [WORD_W-1:0] seed);
    state_t s;
    for (int i = 0; i < NUM_WORDS; i++) begin
      s[i] = INIT_WORDS[i] ^ MIX_WORDS[i];
    end
    s[0] = s[0] ^ seed;
    s[4] = s[4] ^ ror32(seed, 13);
    return s;
  endfunction

  // First half of a quarter round: rotations 16 and 12.
  function automatic quad_t qr_half1(input quad_t q);
    quad_t r;
    r = q;
    r.a = r.a + r.b;
    r.d = ror32(r.d ^ r.a, 16);
    r.c = r.c + r.d;
    r.b = ror32(r.b ^ r.c, 12);
    return r;
  endfunction

  // Second half of a quarter round: rotations 8 and 7.
  function automatic quad_t qr_half2(input quad_t q);
    quad_t r;
    r = q;
    r.a = r.a + r.b;
    r.d = ror32(r.d ^ r.a, 8);
    r.c = r.c + r.d;
    r.b = ror32(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/skmm_front.sv @@
// ----------------------------------------------------------------------------
// skmm_front
// Accepts seeds and turns each into its starting state for the round queue.
// ----------------------------------------------------------------------------
`default_nettype none

module skmm_front
  import skmm_pkg::*;
(
  input  logic              push,
  input  logic [WORD_W-1:0] seed,
  output logic              full,
  input  logic              q_full,
  output logic              q_push,
  output state_t            q_data
);

  // A seed goes straight into the queue; the queue's fill level is the backpressure.
  assign full   = q_full;
  assign q_push = push && !q_full;
  assign q_data = init_state(seed);

endmodule

`default_nettype wire

@@ rtl/core/skmm_queue.sv @@
// ----------------------------------------------------------------------------
// skmm_queue
// Short queue of starting states between the front end and the round engine.
// ----------------------------------------------------------------------------
`default_nettype none

module skmm_queue
  import skmm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  state_t wdata,
  output logic   full,
  input  logic   pop,
  output state_t rdata,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/skmm_core.sv @@
// ----------------------------------------------------------------------------
// skmm_core
// Round engine: eight fmix lanes and two quarter-round units.
// ----------------------------------------------------------------------------
`default_nettype none

module skmm_core
  import skmm_pkg::*;
#(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  state_t q_data,
  input  logic   q_empty,
  output logic   q_pop,
  input  logic   out_busy,
  output logic   out_load,
  output state_t result
);

  localparam int CNT_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MUL1   = 8'b0000_0010,
    S_MUL2   = 8'b0000_0100,
    S_COL_A  = 8'b0000_1000,
    S_COL_B  = 8'b0001_0000,
    S_DIAG_A = 8'b0010_0000,
    S_DIAG_B = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } phase_t;

  phase_t           phase, phase_next;
  state_t           w, w_next;
  logic [CNT_W-1:0] rnd, rnd_next;
  logic             last_round;
  logic [WORD_W-1:0] k;

  assign last_round = (rnd == CNT_W'(ROUNDS - 1));
  assign k          = round_const(RC_IDX_W'(rnd));
  assign result     = w;

  always_comb begin
    logic [WORD_W-1:0] h;
    state_t            t;
    quad_t             q0, q1;
    phase_next = phase;
    w_next     = w;
    rnd_next   = rnd;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    h          = '0;
    t          = w;
    q0         = '0;
    q1         = '0;
    case (phase)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          w_next     = q_data;
          rnd_next   = '0;
          phase_next = S_MUL1;
        end
      end
      S_MUL1: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          h         = w[i] + k;
          h         = h ^ (h >> 16);
          w_next[i] = h * FMIX_C1;
        end
        phase_next = S_MUL2;
      end
      S_MUL2: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          h         = w[i] ^ (w[i] >> 13);
          w_next[i] = h * FMIX_C2;
        end
        phase_next = S_COL_A;
      end
      S_COL_A: begin
        // Last fmix step, then the first half of both column quarter rounds.
        for (int i = 0; i < NUM_WORDS; i++) begin
          t[i] = w[i] ^ (w[i] >> 16);
        end
        q0 = qr_half1('{a: t[0], b: t[1], c: t[2], d: t[3]});
        q1 = qr_half1('{a: t[4], b: t[5], c: t[6], d: t[7]});
        w_next = '{q1.d, q1.c, q1.b, q1.a, q0.d, q0.c, q0.b, q0.a};
        phase_next = S_COL_B;
      end
      S_COL_B: begin
        q0 = qr_half2('{a: w[0], b: w[1], c: w[2], d: w[3]});
        q1 = qr_half2('{a: w[4], b: w[5], c: w[6], d: w[7]});
        w_next = '{q1.d, q1.c, q1.b, q1.a, q0.d, q0.c, q0.b, q0.a};
        phase_next = S_DIAG_A;
      end
      S_DIAG_A: begin
        q0 = qr_half1('{a: w[0], b: w[5], c: w[2], d: w[7]});
        q1 = qr_half1('{a: w[1], b: w[4], c: w[3], d: w[6]});
        w_next = '{q0.d, q1.d, q0.b, q1.b, q1.c, q0.c, q1.a, q0.a};
        phase_next = S_DIAG_B;
      end
      S_DIAG_B: begin
        q0 = qr_half2('{a: w[0], b: w[5], c: w[2], d: w[7]});
        q1 = qr_half2('{a: w[1], b: w[4], c: w[3], d: w[6]});
        w_next = '{q0.d, q1.d, q0.b, q1.b, q1.c, q0.c, q1.a, q0.a};
        if (last_round) begin
          phase_next = S_DONE;
        end else begin
          rnd_next   = rnd + 1'b1;
          phase_next = S_MUL1;
        end
      end
      S_DONE: begin
        // Hand the finished state over and pick up the next seed in the same cycle.
        if (!out_busy) begin
          out_load = 1'b1;
          if (!q_empty) begin
            q_pop      = 1'b1;
            w_next     = q_data;
            rnd_next   = '0;
            phase_next = S_MUL1;
          end else begin
            phase_next = S_IDLE;
          end
        end
      end
      default: begin
        phase_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= S_IDLE;
      rnd   <= '0;
    end else begin
      phase <= phase_next;
      rnd   <= rnd_next;
    end
  end

  always_ff @(posedge clk) begin
    w <= w_next;
  end

endmodule

`default_nettype wire

@@ rtl/core/skmm_out.sv @@
// ----------------------------------------------------------------------------
// skmm_out
// Result buffer: holds one finished state and hands it out one word at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module skmm_out
  import skmm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  state_t                data,
  output logic                  busy,
  input  logic                  pop,
  output logic                  empty,
  output logic [WORD_W-1:0]     key_word,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic                  last
);

  localparam logic [WORD_IDX_W-1:0] LAST_IDX = WORD_IDX_W'(NUM_WORDS - 1);

  state_t                words;
  logic                  valid;
  logic [WORD_IDX_W-1:0] idx;

  assign busy       = valid;
  assign empty      = !valid;
  assign key_word   = words[idx];
  assign word_index = idx;
  assign last       = (idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (load) begin
      words <= data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (pop && valid) begin
      if (last) begin
        valid <= 1'b0;
        idx   <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/seeded_key_material_mixer_top.sv @@
// ----------------------------------------------------------------------------
// seeded_key_material_mixer_top
// Derives eight 32-bit key words from each 32-bit seed.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Word contents
//   -------   ----------------   ----------------------------------------
//   seed in   push / full        seed[31:0]
//   key out   pop / empty        key_word[31:0], word_index[2:0], last
//
// The round engine works through all rounds of one seed before it takes the
// next; that engine, with its eight fmix lanes of two multiplies each, sets
// the sustained seed rate. A seed passes through the queue, every round of
// the engine and the result buffer before its first word leaves.
// Reset is synchronous and clears the seed queue, the engine and the result
// buffer; no clearing pass is needed. The eight words of a seed leave while
// the engine can already work on the next seed, and full rises only once the
// seed queue is full.
//
`default_nettype none

`include "seeded_key_material_mixer_top_defines.svh"

module seeded_key_material_mixer_top
  import skmm_pkg::*;
#(
  parameter int ROUNDS      = ROUNDS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WORD_W-1:0]     seed,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [WORD_W-1:0]     key_word,
  output logic [WORD_IDX_W-1:0] word_index,
  output logic                  last
);

  // Front end to queue.
  logic   q_push;
  state_t q_wdata;
  logic   q_full;

  // Queue to round engine.
  logic   q_pop;
  state_t q_rdata;
  logic   q_empty;

  // Round engine to result buffer.
  logic   core_load;
  state_t core_result;
  logic   out_busy;

  // The front end only forms the starting state; it never waits on the engine.
  skmm_front u_front (
    .push   (push),
    .seed   (seed),
    .full   (full),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  // The queue lets seeds pile up while the engine is busy with an earlier one.
  skmm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The round engine runs all rounds on one seed and then waits for the
  // result buffer to be free before it hands the state over.
  skmm_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_busy (out_busy),
    .out_load (core_load),
    .result   (core_result)
  );

  // The result buffer serializes the state into eight words, index 0 first.
  skmm_out u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (core_load),
    .data       (core_result),
    .busy       (out_busy),
    .pop        (pop),
    .empty      (empty),
    .key_word   (key_word),
    .word_index (word_index),
    .last       (last)
  );

  // A finished state is only handed over into an empty result buffer.
  `SKMM_ASSERT_SAME(a_load_into_free, core_load, !out_busy)
  // The engine never takes a seed from an empty queue.
  `SKMM_ASSERT_SAME(a_pop_nonempty, q_pop, !q_empty)
  // Taking the last word of a seed always drains the result buffer.
  `SKMM_ASSERT_NEXT(a_last_drains, !empty && pop && last, empty)

endmodule

`default_nettype wire
